>>> hw/rtl/fmp_pkg.sv
// Shared types and constants of the framed message parser.
package fmp_pkg;

  // Lengths in a single length byte above this value are refused, unless the byte is the long-length mark.
  localparam logic [7:0] SHORT_LENGTH_LIMIT = 8'd250;

  // Configuration register indexes and their reset values.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE         = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LENGTH_MARK = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH       = 8'd3;

  localparam logic [7:0]  START_BYTE_RST       = 8'd195;
  localparam logic [7:0]  END_BYTE_RST         = 8'd198;
  localparam logic [7:0]  LONG_LENGTH_MARK_RST = 8'hFF;
  localparam logic [15:0] MAX_LENGTH_RST       = 16'd4096;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN_FIRST,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECK,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_SHORT_OVER = 3'd0,
    CAUSE_OVER_MAX   = 3'd1,
    CAUSE_ZERO       = 3'd2,
    CAUSE_CHECKSUM   = 3'd3,
    CAUSE_NO_END     = 3'd4
  } cause_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  long_length_mark;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic        first_payload;
    logic        last_payload;
    logic [15:0] frame_length;
    cause_t      drop_cause;
  } result_t;

endpackage

>>> hw/rtl/fmp_if.sv
// Channel interfaces of the framed message parser: received bytes, results, configuration.
interface fmp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        first_payload;
  logic        last_payload;
  logic [15:0] frame_length;
  logic [2:0]  drop_cause;

  modport source (output valid, output kind, output data, output first_payload,
                  output last_payload, output frame_length, output drop_cause,
                  input ready);
  modport sink   (input valid, input kind, input data, input first_payload,
                  input last_payload, input frame_length, input drop_cause,
                  output ready);
endinterface

interface fmp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fmp_pkg::CFG_INDEX_W-1:0] index;
  logic [15:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/framed_message_parser.sv
// Top level of the framed message parser: channel registers, configuration and parser core.
//
// Recognises frames of the form start byte, length, payload, checksum, end byte in a
// stream of received bytes. The rx channel carries one byte per transfer; the res
// channel carries at most one result per byte: each payload byte as it arrives, then
// a frame accept or a frame discard with its cause. Bytes outside a frame give nothing.
// The cfg channel writes the start byte, end byte, long-length mark and maximum
// length; it is always ready and should only be used while the parser is idle.
// Throughput is one byte per cycle while results are taken: a byte is held in the input
// register, the state machine handles it in a single pass, and its result is registered
// in the output register, from which the result transfer is made.
// Reset (synchronous, active high) returns the parser to waiting for a start byte,
// empties both registers and restores the register defaults. When the receiver
// stalls, the output register holds its result, the input register keeps one byte
// and rx.ready drops until the result is taken.
module framed_message_parser (
  input logic      clk,
  input logic      rst,
  fmp_rx_if.sink   rx,
  fmp_res_if.source res,
  fmp_cfg_if.sink  cfg
);

  fmp_pkg::cfg_t    cfg_regs;
  fmp_pkg::result_t core_res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;

  // The pipeline moves whenever the output register is empty or being emptied.
  assign advance  = !res.valid || res.ready;
  assign rx.ready = !in_valid || advance;
  assign step     = in_valid && advance;
  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_byte       <= fmp_pkg::START_BYTE_RST;
      cfg_regs.end_byte         <= fmp_pkg::END_BYTE_RST;
      cfg_regs.long_length_mark <= fmp_pkg::LONG_LENGTH_MARK_RST;
      cfg_regs.max_length       <= fmp_pkg::MAX_LENGTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fmp_pkg::CFG_START_BYTE:       cfg_regs.start_byte       <= cfg.data[7:0];
        fmp_pkg::CFG_END_BYTE:         cfg_regs.end_byte         <= cfg.data[7:0];
        fmp_pkg::CFG_LONG_LENGTH_MARK: cfg_regs.long_length_mark <= cfg.data[7:0];
        fmp_pkg::CFG_MAX_LENGTH:       cfg_regs.max_length       <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  fmp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg_regs),
    .res     (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.valid) begin
      res.kind          <= core_res.kind;
      res.data          <= core_res.data;
      res.first_payload <= core_res.first_payload;
      res.last_payload  <= core_res.last_payload;
      res.frame_length  <= core_res.frame_length;
      res.drop_cause    <= core_res.drop_cause;
    end
  end

endmodule

>>> hw/rtl/fmp_core.sv
// Frame recognition state machine: one byte per step, at most one result per step.
module fmp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  fmp_pkg::cfg_t    cfg,
  output fmp_pkg::result_t res
);

  fmp_pkg::phase_t phase, phase_next;
  logic [15:0] expected_length, expected_length_next;
  logic [15:0] received_count, received_count_next;
  logic [7:0]  running_sum, running_sum_next;

  // Decoded conditions on the current byte.
  logic        is_mark;
  logic        short_over;
  logic [15:0] len_cand;
  logic        len_zero;
  logic        len_over;
  logic [15:0] count_inc;
  logic        last_byte;
  logic        sum_bad;

  assign is_mark    = (rx_byte == cfg.long_length_mark);
  assign short_over = (rx_byte > fmp_pkg::SHORT_LENGTH_LIMIT);
  assign len_cand   = (phase == fmp_pkg::PH_LEN_LO) ? {expected_length[15:8], rx_byte}
                                                    : {8'h00, rx_byte};
  assign len_zero   = (len_cand == 16'd0);
  assign len_over   = (len_cand > cfg.max_length);
  assign count_inc  = received_count + 16'd1;
  assign last_byte  = (count_inc == expected_length);
  assign sum_bad    = (rx_byte != running_sum);

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      fmp_pkg::PH_WAIT: begin
        if (rx_byte == cfg.start_byte) phase_next = fmp_pkg::PH_LEN_FIRST;
      end
      fmp_pkg::PH_LEN_FIRST: begin
        if (is_mark) phase_next = fmp_pkg::PH_LEN_HI;
        else if (short_over || len_zero || len_over) phase_next = fmp_pkg::PH_WAIT;
        else phase_next = fmp_pkg::PH_PAYLOAD;
      end
      fmp_pkg::PH_LEN_HI: phase_next = fmp_pkg::PH_LEN_LO;
      fmp_pkg::PH_LEN_LO: begin
        if (len_zero || len_over) phase_next = fmp_pkg::PH_WAIT;
        else phase_next = fmp_pkg::PH_PAYLOAD;
      end
      fmp_pkg::PH_PAYLOAD: begin
        if (last_byte) phase_next = fmp_pkg::PH_CHECK;
      end
      fmp_pkg::PH_CHECK: begin
        phase_next = sum_bad ? fmp_pkg::PH_WAIT : fmp_pkg::PH_END;
      end
      fmp_pkg::PH_END: phase_next = fmp_pkg::PH_WAIT;
      default: phase_next = fmp_pkg::PH_WAIT;
    endcase
  end

  // Length, count and checksum updates.
  always_comb begin
    expected_length_next = expected_length;
    received_count_next  = received_count;
    running_sum_next     = running_sum;
    case (phase)
      fmp_pkg::PH_LEN_FIRST, fmp_pkg::PH_LEN_LO: begin
        expected_length_next = len_cand;
        received_count_next  = 16'd0;
        running_sum_next     = 8'd0;
      end
      fmp_pkg::PH_LEN_HI: expected_length_next = {rx_byte, 8'h00};
      fmp_pkg::PH_PAYLOAD: begin
        received_count_next = count_inc;
        running_sum_next    = running_sum + rx_byte;
      end
      default: ;
    endcase
  end

  // Result of the current byte.
  always_comb begin
    res.valid         = 1'b0;
    res.kind          = fmp_pkg::KIND_DATA;
    res.data          = 8'd0;
    res.first_payload = 1'b0;
    res.last_payload  = 1'b0;
    res.frame_length  = expected_length;
    res.drop_cause    = fmp_pkg::CAUSE_SHORT_OVER;
    case (phase)
      fmp_pkg::PH_LEN_FIRST: begin
        if (!is_mark) begin
          res.kind         = fmp_pkg::KIND_DISCARD;
          res.frame_length = len_cand;
          if (short_over) begin
            res.valid      = 1'b1;
            res.drop_cause = fmp_pkg::CAUSE_SHORT_OVER;
          end else if (len_zero) begin
            res.valid      = 1'b1;
            res.drop_cause = fmp_pkg::CAUSE_ZERO;
          end else if (len_over) begin
            res.valid      = 1'b1;
            res.drop_cause = fmp_pkg::CAUSE_OVER_MAX;
          end
        end
      end
      fmp_pkg::PH_LEN_LO: begin
        res.kind         = fmp_pkg::KIND_DISCARD;
        res.frame_length = len_cand;
        if (len_zero) begin
          res.valid      = 1'b1;
          res.drop_cause = fmp_pkg::CAUSE_ZERO;
        end else if (len_over) begin
          res.valid      = 1'b1;
          res.drop_cause = fmp_pkg::CAUSE_OVER_MAX;
        end
      end
      fmp_pkg::PH_PAYLOAD: begin
        res.valid         = 1'b1;
        res.data          = rx_byte;
        res.first_payload = (received_count == 16'd0);
        res.last_payload  = last_byte;
      end
      fmp_pkg::PH_CHECK: begin
        res.kind       = fmp_pkg::KIND_DISCARD;
        res.drop_cause = fmp_pkg::CAUSE_CHECKSUM;
        res.valid      = sum_bad;
      end
      fmp_pkg::PH_END: begin
        res.valid = 1'b1;
        if (rx_byte != cfg.end_byte) begin
          res.kind       = fmp_pkg::KIND_DISCARD;
          res.drop_cause = fmp_pkg::CAUSE_NO_END;
        end else begin
          res.kind = fmp_pkg::KIND_ACCEPT;
        end
      end
      default: ;
    endcase
    res.valid = res.valid & step;
  end

  // State registers advance only when a byte is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= fmp_pkg::PH_WAIT;
      expected_length <= 16'd0;
      received_count  <= 16'd0;
      running_sum     <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      running_sum     <= running_sum_next;
    end
  end

endmodule

>>> hw/rtl/fmp_checker.sv
// Port-level checks of the framed message parser and their binding to the top level.
module fmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  kind,
  input logic [7:0]  data,
  input logic        first_payload,
  input logic        last_payload,
  input logic [15:0] frame_length,
  input logic [2:0]  drop_cause
);

  // A result is never shown in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data)
      && $stable(frame_length) && $stable(drop_cause))
    else $error("stalled result changed");

  // Only payload results carry data and payload marks; they carry no cause.
  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != fmp_pkg::KIND_DATA |->
      data == 8'd0 && !first_payload && !last_payload)
    else $error("frame result carries payload fields");

  // Causes are only given with discards, and only known causes.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == fmp_pkg::KIND_DISCARD && drop_cause <= fmp_pkg::CAUSE_NO_END)
      || ((kind == fmp_pkg::KIND_DATA || kind == fmp_pkg::KIND_ACCEPT)
          && drop_cause == fmp_pkg::CAUSE_SHORT_OVER))
    else $error("bad result kind or drop cause");

endmodule

bind framed_message_parser fmp_checker u_fmp_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .kind          (res.kind),
  .data          (res.data),
  .first_payload (res.first_payload),
  .last_payload  (res.last_payload),
  .frame_length  (res.frame_length),
  .drop_cause    (res.drop_cause)
);
